@@ hw/rtl/fkcd_pkg.sv @@
// fkcd_pkg: shared types and constant tables for the framed keyword command decoder
// holds the keyword tables, frame marks and the event word passed from front to back
// no dependencies
package fkcd_pkg;

    localparam int MAX_BODY_BYTES_DEF = 18;

    localparam logic [7:0] CH_START = 8'h2A;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int KW_NUM     = 8;
    localparam int KW_MAX_LEN = 9;
    localparam int KW_SLOTS   = 16;
    localparam int POS_W      = $clog2(KW_SLOTS);

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_FANOFF,
        CMD_FANON,
        CMD_LIGHT1OFF,
        CMD_LIGHT1ON,
        CMD_LIGHT2OFF,
        CMD_LIGHT2ON,
        CMD_ALLOFF,
        CMD_ALLON
    } cmd_t;

    // keyword text, left aligned and padded to the slot count; padding is never compared
    localparam logic [0:KW_SLOTS-1][7:0] KW_TEXT [KW_NUM] = '{
        "FANOFF          ",
        "FANON           ",
        "LIGHT1OFF       ",
        "LIGHT1ON        ",
        "LIGHT2OFF       ",
        "LIGHT2ON        ",
        "ALLOFF          ",
        "ALLON           "
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_NUM] = '{
        POS_W'(6), POS_W'(5), POS_W'(9), POS_W'(8),
        POS_W'(9), POS_W'(8), POS_W'(6), POS_W'(5)
    };

    typedef struct packed {
        cmd_t code;
        logic invalid;
    } evt_t;

endpackage

@@ hw/rtl/framed_keyword_command_decoder_core.sv @@
// channel  | dir | beat content
// s_*      | in  | tdata[7:0] rx_byte
// m_*      | out | tdata[2:0] command_code, [3] fan_on, [4] lamp1_on, [5] lamp2_on;
//          |     | tuser[0] invalid
// one byte is taken every cycle while the event queue has room; a result is written to
// the event queue and then to the output register after the closing or overflowing byte
// reset (aresetn low, synchronous) drops any open frame, turns all devices off and
// empties the queue and the output register
// a stalled result stalls only the back; the front keeps taking bytes until the
// two-entry event queue fills
// top level; instantiates fkcd_front, fkcd_queue and fkcd_back, depends on fkcd_pkg
module framed_keyword_command_decoder_core import fkcd_pkg::*; #(
    parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [2:0] command_code, [3] fan_on, [4] lamp1_on,
                                   // [5] lamp2_on, [7:6] zero
    output logic       m_tuser     // [0] invalid
);

    logic q_full;
    logic push;
    evt_t push_evt;
    logic pop;
    logic pop_valid;
    evt_t pop_evt;

    fkcd_front #(
        .MAX_BODY_BYTES(MAX_BODY_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_evt (push_evt)
    );

    fkcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_evt  (push_evt),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_evt   (pop_evt)
    );

    fkcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_evt   (pop_evt),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hw/rtl/fkcd_front.sv @@
// fkcd_front: frame tracking and keyword matching, one received byte per beat
// pushes one event per finished frame into the queue; depends on fkcd_pkg
module fkcd_front import fkcd_pkg::*; #(
    parameter int MAX_BODY_BYTES = MAX_BODY_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    input  logic       q_full,
    output logic       push,
    output evt_t       push_evt
);

    localparam int CNT_W = $clog2(MAX_BODY_BYTES + 1);
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(KW_MAX_LEN + 1);

    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  body_count_reg, body_count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [KW_NUM-1:0] alive_reg, alive_next;

    logic accept;
    logic is_end;
    logic overflow;
    logic hit;
    cmd_t hit_code;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_end   = (s_tdata == CH_END);
    assign overflow = (body_count_reg == CNT_W'(MAX_BODY_BYTES));

    // a frame matches the keyword that is still alive and exactly as long
    always_comb begin
        hit      = 1'b0;
        hit_code = CMD_FANOFF;
        for (int i = KW_NUM - 1; i >= 0; i--) begin
            if (alive_reg[i] && (KW_LEN[i] == pos_reg)) begin
                hit      = 1'b1;
                hit_code = cmd_t'(3'(i));
            end
        end
    end

    always_comb begin
        in_frame_next   = in_frame_reg;
        body_count_next = body_count_reg;
        pos_next        = pos_reg;
        alive_next      = alive_reg;
        push            = 1'b0;
        push_evt.code   = CMD_FANOFF;
        push_evt.invalid = 1'b1;
        if (accept) begin
            if (!in_frame_reg) begin
                if (s_tdata == CH_START) begin
                    in_frame_next   = 1'b1;
                    body_count_next = '0;
                    pos_next        = '0;
                    alive_next      = '1;
                end
            end else if (is_end) begin
                in_frame_next    = 1'b0;
                push             = 1'b1;
                push_evt.code    = hit ? hit_code : CMD_FANOFF;
                push_evt.invalid = !hit;
            end else if (overflow) begin
                in_frame_next = 1'b0;
                push          = 1'b1;
            end else begin
                body_count_next = body_count_reg + 1'b1;
                if (s_tdata != CH_SPACE) begin
                    for (int i = 0; i < KW_NUM; i++) begin
                        if ((pos_reg >= KW_LEN[i]) || (KW_TEXT[i][pos_reg] != s_tdata))
                            alive_next[i] = 1'b0;
                    end
                    // past every keyword length all keywords are dead, so stop counting
                    if (pos_reg != POS_SAT)
                        pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            body_count_reg <= '0;
            pos_reg        <= '0;
            alive_reg      <= '1;
        end else begin
            in_frame_reg   <= in_frame_next;
            body_count_reg <= body_count_next;
            pos_reg        <= pos_next;
            alive_reg      <= alive_next;
        end
    end

endmodule

@@ hw/rtl/fkcd_queue.sv @@
// fkcd_queue: short event queue between the frame front and the command back
// register based, depth from fkcd_pkg; depends on fkcd_pkg
module fkcd_queue import fkcd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  evt_t push_evt,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output evt_t pop_evt
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    evt_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_evt   = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push)
            mem[wr_ptr_reg] <= push_evt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/fkcd_back.sv @@
// fkcd_back: applies decoded commands to the device flags and registers the result beat
// pops events from fkcd_queue; depends on fkcd_pkg
module fkcd_back import fkcd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    input  evt_t       pop_evt,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [2:0] command_code, [3] fan_on, [4] lamp1_on,
                                   // [5] lamp2_on, [7:6] zero
    output logic       m_tuser     // [0] invalid
);

    logic [2:0] dev_reg, dev_next;
    logic       m_tvalid_reg, m_tvalid_next;
    cmd_t       code_reg;
    logic       invalid_reg;
    logic [2:0] out_dev_reg;

    // take the next event whenever the output register is free or being drained
    assign pop = pop_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        dev_next = dev_reg;
        if (pop && !pop_evt.invalid) begin
            unique case (pop_evt.code)
                CMD_FANOFF:    dev_next = dev_reg & 3'b110;
                CMD_FANON:     dev_next = dev_reg | 3'b001;
                CMD_LIGHT1OFF: dev_next = dev_reg & 3'b101;
                CMD_LIGHT1ON:  dev_next = dev_reg | 3'b010;
                CMD_LIGHT2OFF: dev_next = dev_reg & 3'b011;
                CMD_LIGHT2ON:  dev_next = dev_reg | 3'b100;
                CMD_ALLOFF:    dev_next = 3'b000;
                CMD_ALLON:     dev_next = 3'b111;
                default:       dev_next = dev_reg;
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (pop)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            dev_reg      <= dev_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            code_reg    <= pop_evt.code;
            invalid_reg <= pop_evt.invalid;
            out_dev_reg <= dev_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_dev_reg, code_reg};
    assign m_tuser  = invalid_reg;

endmodule

@@ tb/sv/framed_keyword_command_decoder_core_tb.sv @@
// testbench for framed_keyword_command_decoder_core: drives received bytes as stream beats
// and checks every command result against a cycle-free software decoder of the frame rules
// depends on fkcd_pkg and the core rtl
`timescale 1ns / 100ps

module framed_keyword_command_decoder_core_tb;
    import fkcd_pkg::*;

    localparam int BODY_LIMIT     = MAX_BODY_BYTES_DEF;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_BYTES   = 960;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_TAIL     = 16;

    localparam int FAN_BIT    = 0;
    localparam int LIGHT1_BIT = 1;
    localparam int LIGHT2_BIT = 2;

    typedef struct {
        cmd_t       code;
        logic       invalid;
        logic [2:0] devs;
    } cmd_result_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;

    // decoder state kept alongside the block
    logic       frame_open = 1'b0;
    logic [5:0] body_bytes = '0;
    logic [4:0] char_pos   = '0;
    logic [7:0] kw_alive   = 8'hFF;
    logic [2:0] dev_state  = 3'b000;

    string kw_text [KW_NUM] = '{"FANOFF", "FANON", "LIGHT1OFF", "LIGHT1ON",
                                "LIGHT2OFF", "LIGHT2ON", "ALLOFF", "ALLON"};

    cmd_result_t pending_commands [$];
    cmd_result_t want;
    int          fail_count  = 0;
    int          idle_cycles = 0;
    int          ready_hold  = 0;
    bit          no_idle     = 1'b0;

    framed_keyword_command_decoder_core #(
        .MAX_BODY_BYTES(BODY_LIMIT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [2:0] apply_command(cmd_t c, logic [2:0] f);
        logic [2:0] n;
        n = f;
        case (c)
            CMD_FANOFF:    n[FAN_BIT]    = 1'b0;
            CMD_FANON:     n[FAN_BIT]    = 1'b1;
            CMD_LIGHT1OFF: n[LIGHT1_BIT] = 1'b0;
            CMD_LIGHT1ON:  n[LIGHT1_BIT] = 1'b1;
            CMD_LIGHT2OFF: n[LIGHT2_BIT] = 1'b0;
            CMD_LIGHT2ON:  n[LIGHT2_BIT] = 1'b1;
            CMD_ALLOFF:    n = 3'b000;
            default:       n = 3'b111;
        endcase
        return n;
    endfunction

    // advance the decoder by one accepted byte, queue the command it closes
    function automatic void predict_decode(logic [7:0] rx);
        cmd_result_t res;
        bit          hit;
        if (!frame_open) begin
            if (rx == CH_START) begin
                frame_open = 1'b1;
                body_bytes = '0;
                char_pos   = '0;
                kw_alive   = 8'hFF;
            end
            return;
        end
        if (rx == CH_END) begin
            frame_open  = 1'b0;
            hit         = 1'b0;
            res.code    = CMD_FANOFF;
            res.invalid = 1'b1;
            for (int i = 0; i < KW_NUM; i++) begin
                if (!hit && kw_alive[i] && kw_text[i].len() == int'(char_pos)) begin
                    hit         = 1'b1;
                    res.code    = cmd_t'(3'(i));
                    res.invalid = 1'b0;
                    dev_state   = apply_command(cmd_t'(3'(i)), dev_state);
                end
            end
            res.devs = dev_state;
            pending_commands.push_back(res);
            return;
        end
        body_bytes = body_bytes + 1'b1;
        if (body_bytes > BODY_LIMIT) begin
            frame_open  = 1'b0;
            res.code    = CMD_FANOFF;
            res.invalid = 1'b1;
            res.devs    = dev_state;
            pending_commands.push_back(res);
            return;
        end
        if (rx != CH_SPACE) begin
            for (int i = 0; i < KW_NUM; i++) begin
                if (kw_alive[i]) begin
                    if (int'(char_pos) >= kw_text[i].len())
                        kw_alive[i] = 1'b0;
                    else if (kw_text[i][char_pos] != rx)
                        kw_alive[i] = 1'b0;
                end
            end
            if (char_pos < 5'd31) char_pos = char_pos + 1'b1;
        end
    endfunction

    task automatic send_byte(logic [7:0] rx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_decode(rx);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_commands.size() != 0) @(posedge aclk);
    endtask

    // well-formed keyword frames mostly, then damaged, overlong and garbage ones
    task automatic random_frame(inout int sent);
        logic [7:0] body [$];
        logic [7:0] b;
        string      text;
        int         kind;
        int         n;
        int         pos;
        text = kw_text[$urandom_range(0, KW_NUM - 1)];
        for (int i = 0; i < text.len(); i++) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) body.push_back(CH_SPACE);
            body.push_back(text[i]);
        end
        if ($urandom_range(0, 9) == 0) body.push_back(CH_SPACE);
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
            // intact keyword
        end else if (kind < 72) begin
            pos = $urandom_range(0, body.size() - 1);
            body[pos] = 8'($urandom_range(0, 255));
        end else if (kind < 77) begin
            pos = $urandom_range(0, body.size() - 1);
            body[pos] = body[pos] ^ 8'h20;
        end else if (kind < 83) begin
            n = $urandom_range(1, body.size());
            repeat (n) void'(body.pop_back());
        end else if (kind < 88) begin
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(8'h30, 8'h5A)));
        end else if (kind < 94) begin
            n = $urandom_range(BODY_LIMIT + 1, BODY_LIMIT + 4);
            while (body.size() < n) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_END) b = CH_SPACE;
                body.push_back(b);
            end
        end else begin
            body.delete();
            repeat ($urandom_range(0, BODY_LIMIT + 2))
                body.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_START);
        foreach (body[i]) send_byte(body[i]);
        send_byte(CH_END);
        sent += body.size() + 2;
    endtask

    task automatic test_hunting_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_END);
        send_byte(CH_SPACE);
        send_text("FANON#");
    endtask

    task automatic test_each_keyword();
        send_text("*FANON#");
        send_text("*LIGHT1ON#");
        send_text("*LIGHT2ON#");
        send_text("*FANOFF#");
        send_text("*LIGHT1OFF#");
        send_text("*LIGHT2OFF#");
        send_text("*ALLON#");
        send_text("*ALLOFF#");
    endtask

    task automatic test_body_special_cases();
        send_text("*#");
        send_text("*   #");
        send_text("**ALLON#");
        send_text("*ALLON#");
        send_text("*FAN");
        send_byte(8'h00);
        send_text("ON#");
        send_text("* F AN O N #");
        send_text("*fanon#");
        send_text("*FAN#");
        send_text("*ALLONN#");
        send_text("*LIGHT1O N#");
    endtask

    task automatic test_body_length_limit();
        // closing mark as the byte right after a full body still ends the frame
        send_byte(CH_START);
        repeat (BODY_LIMIT - 8) send_byte(CH_SPACE);
        send_text("LIGHT2ON#");
        // one byte too many: invalid at once, the mark after it is hunting noise
        send_byte(CH_START);
        repeat (BODY_LIMIT - 7) send_byte(CH_SPACE);
        send_text("LIGHT1ON#");
        send_byte(CH_START);
        repeat (BODY_LIMIT + 1) send_byte("A");
        send_text("FANON#");
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        int sent;
        sent = 0;
        no_idle = 1'b1;
        repeat (12) random_frame(sent);
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int sent;
        int frames;
        sent   = 0;
        frames = 0;
        while (sent < RANDOM_BYTES) begin
            random_frame(sent);
            frames++;
            if (frames % 37 == 0) wait_for_results();
        end
    endtask

    // result side: random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_commands.size() == 0) begin
                $error("unexpected result beat: tdata %h tuser %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_commands.pop_front();
                if (m_tdata[2:0] !== want.code) begin
                    $error("command_code: expected %0d, actual %0d", want.code, m_tdata[2:0]);
                    fail_count++;
                end
                if (m_tuser !== want.invalid) begin
                    $error("invalid: expected %b, actual %b", want.invalid, m_tuser);
                    fail_count++;
                end
                if (m_tdata[3] !== want.devs[FAN_BIT]) begin
                    $error("fan_on: expected %b, actual %b", want.devs[FAN_BIT], m_tdata[3]);
                    fail_count++;
                end
                if (m_tdata[4] !== want.devs[LIGHT1_BIT]) begin
                    $error("lamp1_on: expected %b, actual %b", want.devs[LIGHT1_BIT],
                           m_tdata[4]);
                    fail_count++;
                end
                if (m_tdata[5] !== want.devs[LIGHT2_BIT]) begin
                    $error("lamp2_on: expected %b, actual %b", want.devs[LIGHT2_BIT],
                           m_tdata[5]);
                    fail_count++;
                end
                if (m_tdata[7:6] !== 2'b00) begin
                    $error("tdata padding: expected 0, actual %b", m_tdata[7:6]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_hunting_noise();
        test_each_keyword();
        test_body_special_cases();
        test_body_length_limit();
        test_back_to_back();
        test_random_traffic();
        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
